### rtl/bmcv_pkg.sv
package bmcv_pkg;
    localparam int BLOCKS_ACROSS = 32;
    localparam int BLOCKS_DOWN   = 24;
    localparam int LINE_PITCH    = 256;
    localparam int FRAME_WORDS   = LINE_PITCH * BLOCKS_DOWN * 8;
    localparam int ADDR_W        = $clog2(FRAME_WORDS);
    localparam int SUM_W         = ADDR_W + 2;
    localparam int POS_W         = 9;
    localparam int BLK_W         = 6;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam logic [15:0] KEY_MARK = 16'h8080;
    localparam logic [5:0]  LAST_PIXEL = 6'd63;

    // One command from the classifier to the copy engine
    typedef struct packed {
        logic        is_key;
        logic [15:0] word;
        logic [5:0]  key_idx;
    } bmcv_cmd_t;
endpackage

### rtl/bmcv_front.sv
module bmcv_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [15:0]        s_tdata,   // [15:0] stream_word
    input  logic               clear_busy,
    input  logic               q_full,
    output logic               q_push,
    output bmcv_pkg::bmcv_cmd_t q_cmd
);
    import bmcv_pkg::*;

    logic       in_key_reg, in_key_next;
    logic [5:0] idx_reg, idx_next;
    logic       fire;

    assign s_tready = !clear_busy && !q_full;
    assign fire     = s_tvalid && s_tready;

    always_comb begin
        in_key_next   = in_key_reg;
        idx_next      = idx_reg;
        q_push        = 1'b0;
        q_cmd.is_key  = in_key_reg;
        q_cmd.word    = s_tdata;
        q_cmd.key_idx = idx_reg;
        if (fire) begin
            if (in_key_reg) begin
                q_push   = 1'b1;
                idx_next = idx_reg + 6'd1;
                if (idx_reg == LAST_PIXEL) begin
                    in_key_next = 1'b0;
                end
            end else if (s_tdata == KEY_MARK) begin
                in_key_next = 1'b1;
                idx_next    = '0;
            end else begin
                q_push = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_key_reg <= 1'b0;
            idx_reg    <= '0;
        end else begin
            in_key_reg <= in_key_next;
            idx_reg    <= idx_next;
        end
    end
endmodule

### rtl/bmcv_queue.sv
module bmcv_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  bmcv_pkg::bmcv_cmd_t push_cmd,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output bmcv_pkg::bmcv_cmd_t head_cmd
);
    import bmcv_pkg::*;

    bmcv_cmd_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     count_reg, count_next;

    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end
endmodule

### rtl/bmcv_back.sv
module bmcv_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_not_empty,
    input  bmcv_pkg::bmcv_cmd_t q_head,
    output logic                q_pop,
    output logic                clear_busy,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,
    output logic                m_tlast,
    output logic [1:0]          m_tuser
);
    import bmcv_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_FETCH = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] mem_a [FRAME_WORDS];
    logic [15:0] mem_b [FRAME_WORDS];
    logic [15:0] rd_a_reg, rd_b_reg;

    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [BLK_W-1:0]  bx_reg, bx_next, by_reg, by_next;
    logic              bank_reg, bank_next;
    logic              is_key_reg, is_key_next;
    logic [5:0]        pix_reg, pix_next;
    logic [15:0]       word_reg, word_next;
    logic              oor_reg, oor_next;

    logic              out_valid_reg, out_valid_next;
    logic [7:0]        ox_reg, oy_reg;
    logic [15:0]       oval_reg;
    logic              obank_reg, ooor_reg, olast_reg, odone_reg;

    logic [POS_W-1:0]        cx, cy;
    logic [SUM_W-1:0]        addr_a;
    logic signed [SUM_W-1:0] src;
    logic                    src_ok, tgt_ok;
    logic [ADDR_W-1:0]       rd_addr, wr_addr;
    logic [15:0]             wr_data, ref_data, pix_value;
    logic                    wr_a, wr_b, emit_fire, out_free;
    logic                    block_end, frame_end;

    assign clear_busy = (state_reg == ST_CLEAR);
    assign out_free   = !out_valid_reg || m_tready;

    // Pixel position inside the frame
    assign cx     = POS_W'({bx_reg, 3'b000}) + POS_W'(pix_reg[2:0]);
    assign cy     = POS_W'({by_reg, 3'b000}) + POS_W'(pix_reg[5:3]);
    assign addr_a = SUM_W'(cy) * SUM_W'(LINE_PITCH) + SUM_W'(cx);
    assign tgt_ok = (addr_a < SUM_W'(FRAME_WORDS));
    assign src    = $signed(addr_a) + SUM_W'($signed(word_reg));
    assign src_ok = !src[SUM_W-1] && (src < $signed(SUM_W'(FRAME_WORDS)));
    assign rd_addr = src[ADDR_W-1:0];

    assign ref_data  = bank_reg ? rd_a_reg : rd_b_reg;
    assign pix_value = is_key_reg ? word_reg : (oor_reg ? 16'h0000 : ref_data);

    assign emit_fire = (state_reg == ST_EMIT) && out_free;
    assign block_end = is_key_reg ? (pix_reg == LAST_PIXEL) : (pix_reg == LAST_PIXEL);
    assign frame_end = block_end && (bx_reg == BLK_W'(BLOCKS_ACROSS - 1))
                       && (by_reg == BLK_W'(BLOCKS_DOWN - 1));

    assign wr_addr = clear_busy ? clr_reg : addr_a[ADDR_W-1:0];
    assign wr_data = clear_busy ? 16'h0000 : pix_value;
    assign wr_a    = clear_busy || (emit_fire && tgt_ok && !bank_reg);
    assign wr_b    = clear_busy || (emit_fire && tgt_ok && bank_reg);

    always_ff @(posedge aclk) begin
        if (wr_a) mem_a[wr_addr] <= wr_data;
        rd_a_reg <= mem_a[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (wr_b) mem_b[wr_addr] <= wr_data;
        rd_b_reg <= mem_b[rd_addr];
    end

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        bank_next      = bank_reg;
        is_key_next    = is_key_reg;
        pix_next       = pix_reg;
        word_next      = word_reg;
        oor_next       = oor_reg;
        out_valid_next = out_valid_reg && !m_tready;
        q_pop          = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(FRAME_WORDS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_not_empty) begin
                    q_pop       = 1'b1;
                    is_key_next = q_head.is_key;
                    word_next   = q_head.word;
                    if (q_head.is_key) begin
                        pix_next   = q_head.key_idx;
                        oor_next   = 1'b0;
                        state_next = ST_EMIT;
                    end else begin
                        pix_next   = '0;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                // read issued this cycle; hold the range flag for the write
                oor_next   = !src_ok;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    if (block_end) begin
                        if (frame_end) begin
                            bx_next   = '0;
                            by_next   = '0;
                            bank_next = !bank_reg;
                        end else if (bx_reg == BLK_W'(BLOCKS_ACROSS - 1)) begin
                            bx_next = '0;
                            by_next = by_reg + 1'b1;
                        end else begin
                            bx_next = bx_reg + 1'b1;
                        end
                    end
                    if (!is_key_reg && pix_reg != LAST_PIXEL) begin
                        pix_next   = pix_reg + 6'd1;
                        state_next = ST_FETCH;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            ox_reg    <= cx[7:0];
            oy_reg    <= cy[7:0];
            oval_reg  <= pix_value;
            obank_reg <= bank_reg;
            ooor_reg  <= oor_reg;
            olast_reg <= is_key_reg || (pix_reg == LAST_PIXEL);
            odone_reg <= frame_end;
        end
        is_key_reg <= is_key_next;
        pix_reg    <= pix_next;
        word_reg   <= word_next;
        oor_reg    <= oor_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            bx_reg        <= '0;
            by_reg        <= '0;
            bank_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            bx_reg        <= bx_next;
            by_reg        <= by_next;
            bank_reg      <= bank_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, ooor_reg, oval_reg, oy_reg, ox_reg};
    assign m_tlast  = olast_reg;
    assign m_tuser  = {odone_reg, obank_reg};
endmodule

### rtl/block_motion_copy_video_decoder.sv
// Path: a raw key pixel goes from the command queue through the copy engine's idle and
// emit states into the output register; a moved-block header also passes a fetch state.
// Moved-block pixels: a frame-store read in the fetch state, then write and emit, all 64
// in turn before the engine returns to idle for a new command; a key header queues none.
// Reset: aresetn low clears control state; afterwards both frame stores are swept
// to zero over all 49152 words, with s_tready low throughout the sweep.
module block_motion_copy_video_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] stream_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] pixel_x, [15:8] pixel_y, [31:16] pixel_value,
                                   // [32] ref_out_of_range, [39:33] zero
    output logic        m_tlast,   // last_of_run
    output logic [1:0]  m_tuser    // [0] target_bank, [1] frame_done
);
    import bmcv_pkg::*;

    bmcv_cmd_t push_cmd, head_cmd;
    logic      q_push, q_full, q_pop, q_not_empty, clear_busy;

    // Front: classify stream words, track key-block progress
    bmcv_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .clear_busy (clear_busy),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (push_cmd)
    );

    // Short command queue decoupling classification from the copy engine
    bmcv_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    // Back: frame stores, block walk, bank swap and the output register
    bmcv_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (head_cmd),
        .q_pop       (q_pop),
        .clear_busy  (clear_busy),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    // No input taken while the stores are being swept
    a_no_input_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy |-> !s_tready)
        else $error("input ready during store sweep");

    // No result can appear before the sweep completes
    a_no_output_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy |-> !m_tvalid)
        else $error("result during store sweep");

    // A frame always ends on the last pixel of a run
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> m_tlast)
        else $error("frame_done without last_of_run");

    // An out-of-range reference forces a zero pixel
    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[32]) |-> (m_tdata[31:16] == 16'h0000))
        else $error("out-of-range pixel not zero");
endmodule
